// ----- hw/rtl/fprng_pkg.sv -----
// shared types, constants and round functions for the sha-1 based prng
// no dependencies; used by every module under hw/rtl
package fprng_pkg;

  localparam int KeyWords = 5;
  localparam int SchedDepth = 16;
  localparam int RndW = 7;
  localparam logic [RndW-1:0] LastRound = 7'd79;

  typedef logic [31:0] word_t;
  typedef logic [KeyWords-1:0][31:0] words5_t;

  localparam logic OpLoad = 1'b0;
  localparam logic OpGen  = 1'b1;

  localparam words5_t ShaIv = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                               32'hefcdab89, 32'h67452301};

  typedef struct packed {
    logic        opcode;
    logic [2:0]  word_index;
    logic [31:0] key_word;
  } req_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic [3:0]  out_index;
    logic        last;
  } rsp_t;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_HASH,
    CTL_ADD,
    CTL_EMIT
  } ctl_state_t;

  typedef enum logic [1:0] {
    SHA_IDLE,
    SHA_ROUND,
    SHA_FINAL
  } sha_state_t;

  function automatic word_t rotl(input word_t v, input int unsigned s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

  function automatic word_t round_f(input logic [RndW-1:0] rnd, input word_t b,
                                    input word_t c, input word_t d);
    if (rnd < 7'd20) begin
      round_f = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      round_f = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      round_f = (b & c) | (b & d) | (c & d);
    end else begin
      round_f = b ^ c ^ d;
    end
  endfunction

  function automatic word_t round_k(input logic [RndW-1:0] rnd);
    if (rnd < 7'd20) begin
      round_k = 32'h5A827999;
    end else if (rnd < 7'd40) begin
      round_k = 32'h6ED9EBA1;
    end else if (rnd < 7'd60) begin
      round_k = 32'h8F1BBCDC;
    end else begin
      round_k = 32'hCA62C1D6;
    end
  endfunction

endpackage

// ----- hw/rtl/fprng_sha1_core.sv -----
// sha-1 compression engine, one round per cycle over a 16-word schedule window
// depends on fprng_pkg
module fprng_sha1_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  fprng_pkg::words5_t key,
  output logic              done,
  output fprng_pkg::words5_t digest
);

  fprng_pkg::sha_state_t state, state_next;
  logic [fprng_pkg::RndW-1:0] rnd;
  fprng_pkg::word_t a, b, c, d, e;
  fprng_pkg::word_t sched [fprng_pkg::SchedDepth];
  fprng_pkg::word_t tmp;

  assign tmp = fprng_pkg::rotl(a, 5) + fprng_pkg::round_f(rnd, b, c, d) + e
             + fprng_pkg::round_k(rnd) + sched[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fprng_pkg::SHA_IDLE;
      rnd   <= '0;
    end else begin
      state <= state_next;
      if (start) begin
        rnd <= '0;
      end else if (state == fprng_pkg::SHA_ROUND) begin
        rnd <= rnd + 7'd1;
      end
    end
  end

  always_comb begin
    state_next = state;
    done = 1'b0;
    unique case (state)
      fprng_pkg::SHA_IDLE: begin
        if (start) state_next = fprng_pkg::SHA_ROUND;
      end
      fprng_pkg::SHA_ROUND: begin
        if (rnd == fprng_pkg::LastRound) state_next = fprng_pkg::SHA_FINAL;
      end
      fprng_pkg::SHA_FINAL: begin
        done = 1'b1;
        state_next = fprng_pkg::SHA_IDLE;
      end
      default: state_next = fprng_pkg::SHA_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a <= fprng_pkg::ShaIv[0];
      b <= fprng_pkg::ShaIv[1];
      c <= fprng_pkg::ShaIv[2];
      d <= fprng_pkg::ShaIv[3];
      e <= fprng_pkg::ShaIv[4];
      // key words first, zero padding after
      for (int i = 0; i < fprng_pkg::KeyWords; i++) begin
        sched[i] <= key[i];
      end
      for (int i = fprng_pkg::KeyWords; i < fprng_pkg::SchedDepth; i++) begin
        sched[i] <= '0;
      end
    end else if (state == fprng_pkg::SHA_ROUND) begin
      a <= tmp;
      b <= a;
      c <= fprng_pkg::rotl(b, 30);
      d <= c;
      e <= d;
      for (int i = 0; i < fprng_pkg::SchedDepth - 1; i++) begin
        sched[i] <= sched[i+1];
      end
      sched[fprng_pkg::SchedDepth-1] <=
        fprng_pkg::rotl(sched[13] ^ sched[8] ^ sched[2] ^ sched[0], 1);
    end else if (state == fprng_pkg::SHA_FINAL) begin
      // fold in the chaining value
      a <= a + fprng_pkg::ShaIv[0];
      b <= b + fprng_pkg::ShaIv[1];
      c <= c + fprng_pkg::ShaIv[2];
      d <= d + fprng_pkg::ShaIv[3];
      e <= e + fprng_pkg::ShaIv[4];
    end
  end

  assign digest[0] = a;
  assign digest[1] = b;
  assign digest[2] = c;
  assign digest[3] = d;
  assign digest[4] = e;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == fprng_pkg::SHA_IDLE)
    else $error("compression started while busy");

  a_final_rounds: assert property (@(posedge clk) disable iff (rst)
    state == fprng_pkg::SHA_FINAL |-> rnd == 7'd80)
    else $error("finalize without 80 rounds");

  a_round_run: assert property (@(posedge clk) disable iff (rst)
    state == fprng_pkg::SHA_ROUND && rnd != fprng_pkg::LastRound |=>
      state == fprng_pkg::SHA_ROUND)
    else $error("round sequence cut short");

endmodule

// ----- hw/rtl/fprng_key_store.sv -----
// xkey register file with word loads and a serial 160-bit add, low word first
// depends on fprng_pkg
module fprng_key_store (
  input  logic               clk,
  input  logic               rst,
  input  logic               load_en,
  input  logic [2:0]         load_idx,
  input  fprng_pkg::word_t   load_word,
  input  logic               add_start,
  input  fprng_pkg::words5_t digest,
  output logic               add_done,
  output fprng_pkg::words5_t key
);

  logic       active;
  logic [2:0] idx;
  logic       carry;
  logic [32:0] sum;

  assign sum = {1'b0, key[idx]} + {1'b0, digest[idx]} + {32'd0, carry};
  assign add_done = active && idx == 3'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      key    <= '0;
      active <= 1'b0;
      idx    <= '0;
      carry  <= 1'b0;
    end else begin
      if (load_en && load_idx < 3'(fprng_pkg::KeyWords)) begin
        key[load_idx] <= load_word;
      end
      if (add_start) begin
        // key + w + 1: the +1 enters as the first carry
        active <= 1'b1;
        idx    <= 3'(fprng_pkg::KeyWords - 1);
        carry  <= 1'b1;
      end else if (active) begin
        key[idx] <= sum[31:0];
        carry    <= sum[32];
        if (idx == 3'd0) begin
          active <= 1'b0;
        end else begin
          idx <= idx - 3'd1;
        end
      end
    end
  end

  a_add_start_idle: assert property (@(posedge clk) disable iff (rst)
    add_start |-> !active)
    else $error("key add restarted while running");

  a_no_load_in_add: assert property (@(posedge clk) disable iff (rst)
    load_en |-> !active && !add_start)
    else $error("key load during key update");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    active |-> idx < 3'(fprng_pkg::KeyWords))
    else $error("key add index out of range");

endmodule

// ----- hw/rtl/fips186_prng_sha1_generator.sv -----
// top level of the fips 186-2 sha-1 prng: control sequencer and output register
// depends on fprng_pkg, fprng_sha1_core, fprng_key_store
//
// channel  dir  handshake            word
// req      in   req_valid/req_ready  fprng_pkg::req_t (opcode, word_index, key_word)
// rsp      out  rsp_valid/rsp_ready  fprng_pkg::rsp_t (out_word, out_index, last)
//
// a load word writes one xkey word when it is accepted
// a generate word runs, from acceptance until req_ready returns, twice through
//   the single-round sha-1 engine (all rounds, then finalize), the serial key
//   add and the emit of five words; the second hash starts when the fifth word
//   is emitted, the round engine sets the pace
// rst (synchronous) clears xkey to zero and returns all control to idle
// a stalled rsp holds the emit sequence; req_ready stays low until the tenth
//   result word is registered, the output register may still be waiting then
module fips186_prng_sha1_generator (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  fprng_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output fprng_pkg::rsp_t rsp
);

  fprng_pkg::ctl_state_t state, state_next;
  logic               half;
  logic [2:0]         cnt;
  logic               accept;
  logic               load_en;
  logic               sha_start;
  logic               sha_done;
  logic               add_start;
  logic               add_done;
  logic               emit_fire;
  fprng_pkg::words5_t key;
  fprng_pkg::words5_t digest;

  assign req_ready = (state == fprng_pkg::CTL_IDLE);
  assign accept    = req_valid && req_ready;
  assign load_en   = accept && req.opcode == fprng_pkg::OpLoad;
  // the output register is free, or its word leaves this cycle
  assign emit_fire = (state == fprng_pkg::CTL_EMIT) && (!rsp_valid || rsp_ready);

  fprng_sha1_core u_core (
    .clk    (clk),
    .rst    (rst),
    .start  (sha_start),
    .key    (key),
    .done   (sha_done),
    .digest (digest)
  );

  fprng_key_store u_key (
    .clk       (clk),
    .rst       (rst),
    .load_en   (load_en),
    .load_idx  (req.word_index),
    .load_word (req.key_word),
    .add_start (add_start),
    .digest    (digest),
    .add_done  (add_done),
    .key       (key)
  );

  // sequencer: hash, update xkey, emit five words, twice per generate
  always_comb begin
    state_next = state;
    sha_start  = 1'b0;
    add_start  = 1'b0;
    unique case (state)
      fprng_pkg::CTL_IDLE: begin
        if (accept && req.opcode == fprng_pkg::OpGen) begin
          sha_start  = 1'b1;
          state_next = fprng_pkg::CTL_HASH;
        end
      end
      fprng_pkg::CTL_HASH: begin
        if (sha_done) begin
          add_start  = 1'b1;
          state_next = fprng_pkg::CTL_ADD;
        end
      end
      fprng_pkg::CTL_ADD: begin
        if (add_done) state_next = fprng_pkg::CTL_EMIT;
      end
      fprng_pkg::CTL_EMIT: begin
        if (emit_fire && cnt == 3'(fprng_pkg::KeyWords - 1)) begin
          if (half) begin
            state_next = fprng_pkg::CTL_IDLE;
          end else begin
            // second value w1 from the updated key
            sha_start  = 1'b1;
            state_next = fprng_pkg::CTL_HASH;
          end
        end
      end
      default: state_next = fprng_pkg::CTL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fprng_pkg::CTL_IDLE;
      half      <= 1'b0;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        half <= 1'b0;
      end else if (emit_fire && cnt == 3'(fprng_pkg::KeyWords - 1)) begin
        half <= 1'b1;
      end
      if (add_done) begin
        cnt <= '0;
      end else if (emit_fire) begin
        cnt <= cnt + 3'd1;
      end
      if (emit_fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      rsp.out_word  <= digest[cnt];
      rsp.out_index <= (half ? 4'd5 : 4'd0) + {1'b0, cnt};
      rsp.last      <= half && cnt == 3'(fprng_pkg::KeyWords - 1);
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> state == fprng_pkg::CTL_IDLE && !add_done)
    else $error("request taken while engine busy");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.last |-> rsp.out_index == 4'd9)
    else $error("last flag on wrong word");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.out_index <= 4'd9)
    else $error("output index out of range");

  a_done_in_hash: assert property (@(posedge clk) disable iff (rst)
    sha_done |-> state == fprng_pkg::CTL_HASH)
    else $error("compression finished outside hash phase");

endmodule
